FILE: hw/rtl/apm_pkg.sv
// Shared types and constants of the attitude PD mixer.
package apm_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE_SELECT  = 3'd0;
    localparam logic [2:0] REG_STICK_CENTER = 3'd1;
    localparam logic [2:0] REG_STICK_GAIN   = 3'd2;
    localparam logic [2:0] REG_PROP_GAIN    = 3'd3;
    localparam logic [2:0] REG_RATE_GAIN    = 3'd4;
    localparam logic [2:0] REG_RUDDER_MIX   = 3'd5;
    localparam logic [2:0] REG_OUT_MID      = 3'd6;
    localparam logic [2:0] REG_OUT_MIN      = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Reset values
    localparam logic [3:0]  RST_MODE_SELECT  = 4'hF;
    localparam logic [11:0] RST_STICK_CENTER = 12'd1500;
    localparam logic [15:0] RST_STICK_GAIN   = 16'd2560;
    localparam logic [15:0] RST_PROP_GAIN    = 16'd26;
    localparam logic [15:0] RST_RATE_GAIN    = 16'd5;
    localparam logic [7:0]  RST_RUDDER_MIX   = 8'd128;
    localparam logic [11:0] RST_OUT_MID      = 12'd1500;
    localparam logic [11:0] RST_OUT_MIN      = 12'd1000;

    // Mode codes
    localparam logic signed [3:0] SEL_BY_SWITCH = -4'sd1;
    localparam logic [2:0] MODE_MANUAL  = 3'd0;
    localparam logic [2:0] MODE_PD      = 3'd1;
    localparam logic [2:0] MODE_PD_LAST = 3'd5;
    localparam logic [2:0] MODE_BAD_SEL = 3'd7;

    localparam int DRIVE_LIMIT = 500;
    localparam int OUT_MAX     = 4095;

    typedef struct packed {
        logic [3:0]  mode_select;
        logic [11:0] stick_center;
        logic [15:0] stick_gain;
        logic [15:0] prop_gain;
        logic [15:0] rate_gain;
        logic [7:0]  rudder_mix;
        logic [11:0] out_mid;
        logic [11:0] out_min;
    } cfg_t;

endpackage

FILE: hw/rtl/apm_cfg_regs.sv
// Configuration register bank of the attitude PD mixer.
module apm_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [apm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [apm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output apm_pkg::cfg_t                  cfg
);

    apm_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_select  <= apm_pkg::RST_MODE_SELECT;
            cfg_reg.stick_center <= apm_pkg::RST_STICK_CENTER;
            cfg_reg.stick_gain   <= apm_pkg::RST_STICK_GAIN;
            cfg_reg.prop_gain    <= apm_pkg::RST_PROP_GAIN;
            cfg_reg.rate_gain    <= apm_pkg::RST_RATE_GAIN;
            cfg_reg.rudder_mix   <= apm_pkg::RST_RUDDER_MIX;
            cfg_reg.out_mid      <= apm_pkg::RST_OUT_MID;
            cfg_reg.out_min      <= apm_pkg::RST_OUT_MIN;
        end else if (cfg_we) begin
            case (cfg_addr)
                apm_pkg::REG_MODE_SELECT:  cfg_reg.mode_select  <= cfg_wdata[3:0];
                apm_pkg::REG_STICK_CENTER: cfg_reg.stick_center <= cfg_wdata[11:0];
                apm_pkg::REG_STICK_GAIN:   cfg_reg.stick_gain   <= cfg_wdata;
                apm_pkg::REG_PROP_GAIN:    cfg_reg.prop_gain    <= cfg_wdata;
                apm_pkg::REG_RATE_GAIN:    cfg_reg.rate_gain    <= cfg_wdata;
                apm_pkg::REG_RUDDER_MIX:   cfg_reg.rudder_mix   <= cfg_wdata[7:0];
                apm_pkg::REG_OUT_MID:      cfg_reg.out_mid      <= cfg_wdata[11:0];
                apm_pkg::REG_OUT_MIN:      cfg_reg.out_min      <= cfg_wdata[11:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/attitude_pd_mixer_core.sv
// Top level of the attitude PD mixer: six-stage pipelined control law and mixer.
//
//  channel   | direction | handshake                | contents
//  ----------+-----------+--------------------------+-----------------------------------
//  s_        | in        | s_tvalid / s_tready      | sticks, switch, angles, rates
//  m_        | out       | m_tvalid / m_tready      | four output pulse widths, mode
//  cfg_      | in        | cfg_we (no wait)         | register index and write data
//
//  Rate: one request per cycle while m_tready stays high; a full pipeline stalls s_tready.
//  The six register stages are: stick and rate products, angle errors, proportional
//  products, PD sums, rudder product and clamps, output register.
//  Reset: aresetn (synchronous, low) clears all valid bits and restores register defaults.
//  Stalls: each stage holds its request until the next stage is free; empty stages
//  fill up, so s_tready stays high while any stage downstream is empty.
module attitude_pd_mixer_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // throttle_stick[11:0], aileron_stick[23:12], elevator_stick[35:24],
    // rudder_stick[47:36], autopilot_stick[59:48], roll_angle[75:60],
    // pitch_angle[90:76], roll gyro rate[109:91], pitch gyro rate[128:110], zero fill
    input  logic [135:0]                   s_tdata,
    // Results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // throttle_out[11:0], aileron_out[23:12], elevator_out[35:24],
    // rudder_out[47:36], active_mode[50:48], zero fill
    output logic [55:0]                    m_tdata,
    // Configuration writes
    input  logic                           cfg_we,
    input  logic [apm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [apm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int STAGES = 6;

    apm_pkg::cfg_t cfg;

    apm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Drive clamp to +-500
    function automatic logic signed [9:0] clamp_drive(input logic signed [32:0] v);
        logic signed [9:0] r;
        if (v > 33'(apm_pkg::DRIVE_LIMIT))
            r = 10'(apm_pkg::DRIVE_LIMIT);
        else if (v < -33'(apm_pkg::DRIVE_LIMIT))
            r = -10'(apm_pkg::DRIVE_LIMIT);
        else
            r = v[9:0];
        return r;
    endfunction

    // Saturate a centered drive to the 12-bit pulse range
    function automatic logic [11:0] sat_out(input logic signed [13:0] v);
        logic [11:0] r;
        if (v < 14'sd0)
            r = 12'd0;
        else if (v > 14'(apm_pkg::OUT_MAX))
            r = 12'(apm_pkg::OUT_MAX);
        else
            r = v[11:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when it empties
    // ------------------------------------------------------------------
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] rdy;

    always_comb begin
        rdy[STAGES-1] = !v_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[STAGES-1];

    // Input unpack
    logic [11:0]        in_thr, in_ail, in_ele, in_rud, in_ap;
    logic signed [15:0] in_roll;
    logic signed [14:0] in_pitch;
    logic signed [18:0] in_roll_gyro, in_pitch_gyro;

    assign in_thr        = s_tdata[11:0];
    assign in_ail        = s_tdata[23:12];
    assign in_ele        = s_tdata[35:24];
    assign in_rud        = s_tdata[47:36];
    assign in_ap         = s_tdata[59:48];
    assign in_roll       = $signed(s_tdata[75:60]);
    assign in_pitch      = $signed(s_tdata[90:76]);
    assign in_roll_gyro  = $signed(s_tdata[109:91]);
    assign in_pitch_gyro = $signed(s_tdata[128:110]);

    // Pass-through fields, carried alongside stages 1 to 5; the mode is carried to stage 6
    logic [11:0] thr_reg [STAGES-1];
    logic [11:0] ail_reg [STAGES-1];
    logic [11:0] ele_reg [STAGES-1];
    logic [11:0] rud_reg [STAGES-1];
    logic [2:0]  mode_reg [STAGES];

    // ------------------------------------------------------------------
    // Stage 1: mode decode, stick offsets times stick gain, rate terms
    // ------------------------------------------------------------------
    logic signed [3:0]  sel;
    logic [2:0]         mode_next;
    logic signed [12:0] roll_ofs, pitch_ofs;
    logic signed [28:0] rcmd_prod_next, pcmd_prod_next;
    logic signed [35:0] rrate_next, prate_next;
    logic signed [28:0] rcmd_prod_reg, pcmd_prod_reg;
    logic signed [35:0] rrate_reg [2:4];
    logic signed [35:0] prate_reg [2:4];
    logic signed [15:0] roll1_reg;
    logic signed [14:0] pitch1_reg;

    always_comb begin
        sel = $signed(cfg.mode_select);
        if (sel == apm_pkg::SEL_BY_SWITCH)
            mode_next = (in_ap > cfg.stick_center) ? apm_pkg::MODE_PD : apm_pkg::MODE_MANUAL;
        else if (sel < 4'sd0)
            mode_next = apm_pkg::MODE_BAD_SEL;
        else
            mode_next = sel[2:0];
        roll_ofs       = $signed({1'b0, in_ail}) - $signed({1'b0, cfg.stick_center});
        pitch_ofs      = $signed({1'b0, cfg.stick_center}) - $signed({1'b0, in_ele});
        rcmd_prod_next = roll_ofs * $signed({1'b0, cfg.stick_gain});
        pcmd_prod_next = pitch_ofs * $signed({1'b0, cfg.stick_gain});
        rrate_next     = in_roll_gyro * $signed({1'b0, cfg.rate_gain});
        prate_next     = in_pitch_gyro * $signed({1'b0, cfg.rate_gain});
    end

    // ------------------------------------------------------------------
    // Stage 2: angle errors
    // ------------------------------------------------------------------
    logic signed [21:0] rerr_next, perr_next, rerr_reg, perr_reg;

    always_comb begin
        rerr_next = 22'(roll1_reg)  - 22'($signed(rcmd_prod_reg[28:8]));
        perr_next = 22'(pitch1_reg) - 22'($signed(pcmd_prod_reg[28:8]));
    end

    // ------------------------------------------------------------------
    // Stage 3: proportional terms
    // ------------------------------------------------------------------
    logic signed [38:0] rkp_next, pkp_next, rkp_reg, pkp_reg;

    always_comb begin
        rkp_next = rerr_reg * $signed({1'b0, cfg.prop_gain});
        pkp_next = perr_reg * $signed({1'b0, cfg.prop_gain});
    end

    // ------------------------------------------------------------------
    // Stage 4: PD sums, floor by 256
    // ------------------------------------------------------------------
    logic signed [39:0] rsum, psum;
    logic signed [31:0] ail_drv_next, ele_drv_next, ail_drv_reg, ele_drv_reg;

    always_comb begin
        rsum         = 40'(rkp_reg) + 40'(rrate_reg[4]);
        psum         = 40'(pkp_reg) + 40'(prate_reg[4]);
        ail_drv_next = rsum[39:8];
        ele_drv_next = psum[39:8];
    end

    // ------------------------------------------------------------------
    // Stage 5: rudder mix product, clamp aileron and elevator
    // ------------------------------------------------------------------
    logic signed [40:0] rud_prod_next, rud_prod_reg;
    logic signed [9:0]  ail_clp_next, ele_clp_next, ail_clp_reg, ele_clp_reg;

    always_comb begin
        rud_prod_next = ail_drv_reg * $signed({1'b0, cfg.rudder_mix});
        ail_clp_next  = clamp_drive(33'(ail_drv_reg));
        ele_clp_next  = clamp_drive(33'(ele_drv_reg));
    end

    // ------------------------------------------------------------------
    // Stage 6 (output register): rudder clamp, centering, mode select
    // ------------------------------------------------------------------
    logic signed [9:0]  rud_clp;
    logic signed [13:0] omid_s;
    logic [11:0]        thr_out_next, ail_out_next, ele_out_next, rud_out_next;
    logic [11:0]        thr_out_reg, ail_out_reg, ele_out_reg, rud_out_reg;
    logic [2:0]         mode_in5;

    always_comb begin
        mode_in5 = mode_reg[4];
        rud_clp  = clamp_drive($signed(rud_prod_reg[40:8]));
        omid_s   = $signed({2'b00, cfg.out_mid});
        if (mode_in5 == apm_pkg::MODE_MANUAL) begin
            thr_out_next = thr_reg[4];
            ail_out_next = ail_reg[4];
            ele_out_next = ele_reg[4];
            rud_out_next = rud_reg[4];
        end else if (mode_in5 <= apm_pkg::MODE_PD_LAST) begin
            thr_out_next = thr_reg[4];
            ail_out_next = sat_out(omid_s - 14'(ail_clp_reg));
            ele_out_next = sat_out(omid_s + 14'(ele_clp_reg));
            rud_out_next = sat_out(omid_s + 14'(rud_clp));
        end else begin
            thr_out_next = cfg.out_min;
            ail_out_next = cfg.out_mid;
            ele_out_next = cfg.out_mid;
            rud_out_next = cfg.out_mid;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            thr_reg[0]    <= in_thr;
            ail_reg[0]    <= in_ail;
            ele_reg[0]    <= in_ele;
            rud_reg[0]    <= in_rud;
            mode_reg[0]   <= mode_next;
            roll1_reg     <= in_roll;
            pitch1_reg    <= in_pitch;
            rcmd_prod_reg <= rcmd_prod_next;
            pcmd_prod_reg <= pcmd_prod_next;
            rrate_reg[2]  <= rrate_next;
            prate_reg[2]  <= prate_next;
        end
        for (int i = 1; i < STAGES - 1; i++) begin
            if (rdy[i]) begin
                thr_reg[i]  <= thr_reg[i-1];
                ail_reg[i]  <= ail_reg[i-1];
                ele_reg[i]  <= ele_reg[i-1];
                rud_reg[i]  <= rud_reg[i-1];
                mode_reg[i] <= mode_reg[i-1];
            end
        end
        if (rdy[1]) begin
            rerr_reg     <= rerr_next;
            perr_reg     <= perr_next;
            rrate_reg[3] <= rrate_reg[2];
            prate_reg[3] <= prate_reg[2];
        end
        if (rdy[2]) begin
            rkp_reg      <= rkp_next;
            pkp_reg      <= pkp_next;
            rrate_reg[4] <= rrate_reg[3];
            prate_reg[4] <= prate_reg[3];
        end
        if (rdy[3]) begin
            ail_drv_reg <= ail_drv_next;
            ele_drv_reg <= ele_drv_next;
        end
        if (rdy[4]) begin
            rud_prod_reg <= rud_prod_next;
            ail_clp_reg  <= ail_clp_next;
            ele_clp_reg  <= ele_clp_next;
        end
        if (rdy[5]) begin
            thr_out_reg     <= thr_out_next;
            ail_out_reg     <= ail_out_next;
            ele_out_reg     <= ele_out_next;
            rud_out_reg     <= rud_out_next;
            mode_reg[5]     <= mode_reg[4];
        end
    end

    assign m_tdata = {5'b0, mode_reg[5], rud_out_reg, ele_out_reg, ail_out_reg, thr_out_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A request in a stage whose successor is busy must still be there next cycle.
    a_stall_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[3] && !rdy[4]) |=> (v_reg[3] && $stable(ail_drv_reg) && $stable(ele_drv_reg)))
        else $error("stalled stage 4 lost or changed its request");

    // A request leaving stage 4 lands in stage 5.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[3] && rdy[4]) |=> v_reg[4])
        else $error("request dropped between stages 4 and 5");

    // Clamped drives stay inside the drive limit.
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[4] |-> (ail_clp_reg <= 10'sd500 && ail_clp_reg >= -10'sd500 &&
                      ele_clp_reg <= 10'sd500 && ele_clp_reg >= -10'sd500))
        else $error("clamped drive out of range");

endmodule

FILE: verif/tb_attitude_pd_mixer_core.sv
// Self-checking testbench for attitude_pd_mixer_core: directed and random stick/sensor samples.
`timescale 1ns / 1ps

// One input request, laid out exactly as s_tdata (throttle in the low bits).
typedef struct packed {
    logic [6:0]         pad;
    logic signed [18:0] pitch_gyro;
    logic signed [18:0] roll_gyro;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic [11:0]        autopilot;
    logic [11:0]        rudder;
    logic [11:0]        elevator;
    logic [11:0]        aileron;
    logic [11:0]        throttle;
} stick_sample_t;

// One result, laid out exactly as m_tdata.
typedef struct packed {
    logic [4:0]  pad;
    logic [2:0]  mode;
    logic [11:0] rudder;
    logic [11:0] elevator;
    logic [11:0] aileron;
    logic [11:0] throttle;
} servo_out_t;

class servo_scoreboard;
    apm_pkg::cfg_t regs;
    servo_out_t    expected_servos[$];
    int            errors;
    int            checked;
    int            mode_hits[8];

    function new();
        regs.mode_select  = apm_pkg::RST_MODE_SELECT;
        regs.stick_center = apm_pkg::RST_STICK_CENTER;
        regs.stick_gain   = apm_pkg::RST_STICK_GAIN;
        regs.prop_gain    = apm_pkg::RST_PROP_GAIN;
        regs.rate_gain    = apm_pkg::RST_RATE_GAIN;
        regs.rudder_mix   = apm_pkg::RST_RUDDER_MIX;
        regs.out_mid      = apm_pkg::RST_OUT_MID;
        regs.out_min      = apm_pkg::RST_OUT_MIN;
        errors  = 0;
        checked = 0;
        foreach (mode_hits[i]) mode_hits[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            apm_pkg::REG_MODE_SELECT:  regs.mode_select  = val[3:0];
            apm_pkg::REG_STICK_CENTER: regs.stick_center = val[11:0];
            apm_pkg::REG_STICK_GAIN:   regs.stick_gain   = val;
            apm_pkg::REG_PROP_GAIN:    regs.prop_gain    = val;
            apm_pkg::REG_RATE_GAIN:    regs.rate_gain    = val;
            apm_pkg::REG_RUDDER_MIX:   regs.rudder_mix   = val[7:0];
            apm_pkg::REG_OUT_MID:      regs.out_mid      = val[11:0];
            apm_pkg::REG_OUT_MIN:      regs.out_min      = val[11:0];
            default: ;
        endcase
    endfunction

    function longint limit_drive(longint v);
        if (v > apm_pkg::DRIVE_LIMIT) return apm_pkg::DRIVE_LIMIT;
        if (v < -apm_pkg::DRIVE_LIMIT) return -apm_pkg::DRIVE_LIMIT;
        return v;
    endfunction

    function logic [11:0] to_pulse(longint v);
        if (v < 0) v = 0;
        if (v > apm_pkg::OUT_MAX) v = apm_pkg::OUT_MAX;
        return v[11:0];
    endfunction

    // PD law and mixer; >>> 8 on a signed longint is a floor division by 256.
    function servo_out_t mix_servos(stick_sample_t s);
        servo_out_t       r;
        logic signed [3:0] sel;
        logic [2:0]       mode;
        longint           mid, omid, sg, kp, kd;
        longint           roll_cmd, pitch_cmd, ail, ele, rud;
        r    = '0;
        sel  = $signed(regs.mode_select);
        mid  = longint'(regs.stick_center);
        omid = longint'(regs.out_mid);
        sg   = longint'(regs.stick_gain);
        kp   = longint'(regs.prop_gain);
        kd   = longint'(regs.rate_gain);
        if (sel == apm_pkg::SEL_BY_SWITCH)
            mode = (s.autopilot > regs.stick_center) ? apm_pkg::MODE_PD : apm_pkg::MODE_MANUAL;
        else if (sel < 0)
            mode = apm_pkg::MODE_BAD_SEL;
        else
            mode = sel[2:0];

        if (mode == apm_pkg::MODE_MANUAL) begin
            r.throttle = s.throttle;
            r.aileron  = s.aileron;
            r.elevator = s.elevator;
            r.rudder   = s.rudder;
        end else if (mode <= apm_pkg::MODE_PD_LAST) begin
            roll_cmd  = ((longint'(s.aileron) - mid) * sg) >>> 8;
            pitch_cmd = ((mid - longint'(s.elevator)) * sg) >>> 8;
            ail = (kp * (longint'($signed(s.roll_angle)) - roll_cmd)
                   + kd * longint'($signed(s.roll_gyro))) >>> 8;
            ele = (kp * (longint'($signed(s.pitch_angle)) - pitch_cmd)
                   + kd * longint'($signed(s.pitch_gyro))) >>> 8;
            rud = (ail * longint'(regs.rudder_mix)) >>> 8;
            r.throttle = s.throttle;
            r.aileron  = to_pulse(omid - limit_drive(ail));
            r.elevator = to_pulse(omid + limit_drive(ele));
            r.rudder   = to_pulse(omid + limit_drive(rud));
        end else begin
            r.throttle = regs.out_min;
            r.aileron  = regs.out_mid;
            r.elevator = regs.out_mid;
            r.rudder   = regs.out_mid;
        end
        r.mode = mode;
        return r;
    endfunction

    function void note_request(stick_sample_t s);
        expected_servos.push_back(mix_servos(s));
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(servo_out_t got);
        servo_out_t want;
        if (expected_servos.size() == 0) begin
            $error("result %h arrived with no request outstanding", got);
            errors++;
            return;
        end
        want = expected_servos.pop_front();
        checked++;
        compare_field("throttle_out", want.throttle, got.throttle);
        compare_field("aileron_out", want.aileron, got.aileron);
        compare_field("elevator_out", want.elevator, got.elevator);
        compare_field("rudder_out", want.rudder, got.rudder);
        compare_field("active_mode", {9'b0, want.mode}, {9'b0, got.mode});
        mode_hits[want.mode]++;
    endfunction

    function int outstanding();
        return expected_servos.size();
    endfunction
endclass

module tb_attitude_pd_mixer_core;

    localparam int CYCLE_LIMIT   = 400000;
    // Pipeline is six stages deep; the drain margin is extra idle time after the last result.
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 110;
    localparam logic signed [3:0] SEL_MOST_NEG = -4'sd8;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [135:0]                   s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [55:0]                    m_tdata;
    logic                           cfg_we    = 1'b0;
    logic [apm_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [apm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    servo_scoreboard sb;
    apm_pkg::cfg_t   settings;      // register image the stimulus wants loaded next
    int              stall_pct = 0; // receiver back-pressure, percent of cycles
    int              cycles    = 0;
    int              requests  = 0;
    int              loads     = 0;

    attitude_pd_mixer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Random back-pressure on the result side; zero percent keeps m_tready high.
    always @(posedge aclk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99, 0) >= stall_pct);
    end

    // Both handshakes are observed with pre-edge values; every stimulus drive is nonblocking.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycles, sb.outstanding());
            $display("attitude_pd_mixer_core regression: fail");
            $finish;
        end
    end

    function automatic int clip12(int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    // Symmetric random value in [-r, r].
    function automatic int spread(int r);
        return int'($urandom_range(2 * r, 0)) - r;
    endfunction

    function automatic int near(int c, int r);
        return clip12(c + spread(r));
    endfunction

    function automatic stick_sample_t make_sample(int th, int ai, int el, int ru, int ap,
                                                  int roll, int pitch, int rr, int pr);
        stick_sample_t s;
        s             = '0;
        s.throttle    = 12'(th);
        s.aileron     = 12'(ai);
        s.elevator    = 12'(el);
        s.rudder      = 12'(ru);
        s.autopilot   = 12'(ap);
        s.roll_angle  = 16'(roll);
        s.pitch_angle = 15'(pitch);
        s.roll_gyro   = 19'(rr);
        s.pitch_gyro  = 19'(pr);
        return s;
    endfunction

    // Mostly flight-like samples around the stick center; the rest spans the documented
    // ranges or raw field bits.
    function automatic stick_sample_t random_sample();
        stick_sample_t s;
        logic [159:0]  bits;
        int            pick, mid, ap;
        pick = $urandom_range(99, 0);
        mid  = int'(settings.stick_center);
        ap   = $urandom_range(1, 0) ? int'($urandom_range(4095, 0)) : near(mid, 2);
        if (pick < 65) begin
            s = make_sample($urandom_range(4095, 0), near(mid, 400), near(mid, 400),
                            near(mid, 400), ap, spread(3000), spread(2000),
                            spread(30000), spread(30000));
        end else if (pick < 85) begin
            s = make_sample($urandom_range(4095, 0), $urandom_range(4095, 0),
                            $urandom_range(4095, 0), $urandom_range(4095, 0), ap,
                            spread(18000), spread(9000), spread(200000), spread(200000));
        end else begin
            bits  = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            s     = bits[135:0];
            s.pad = '0;
        end
        return s;
    endfunction

    task automatic send(stick_sample_t s);
        s_tdata  <= s;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests++;
    endtask

    task automatic sender_gap(int pct);
        if (pct != 0 && $urandom_range(99, 0) < pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge aclk);
        end
    endtask

    // Hold the sender off until every accepted request has produced its result.
    task automatic drain_results(int extra);
        s_tvalid <= 1'b0;
        while (sb.checked != requests) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_one(logic [2:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // Registers are only touched with the pipeline empty.
    task automatic apply_settings();
        drain_results(DRAIN_CYCLES);
        write_one(apm_pkg::REG_MODE_SELECT, {12'b0, settings.mode_select});
        write_one(apm_pkg::REG_STICK_CENTER, {4'b0, settings.stick_center});
        write_one(apm_pkg::REG_STICK_GAIN, settings.stick_gain);
        write_one(apm_pkg::REG_PROP_GAIN, settings.prop_gain);
        write_one(apm_pkg::REG_RATE_GAIN, settings.rate_gain);
        write_one(apm_pkg::REG_RUDDER_MIX, {8'b0, settings.rudder_mix});
        write_one(apm_pkg::REG_OUT_MID, {4'b0, settings.out_mid});
        write_one(apm_pkg::REG_OUT_MIN, {4'b0, settings.out_min});
        cfg_we <= 1'b0;
        loads++;
    endtask

    task automatic pick_settings(int phase);
        settings = sb.regs;
        case (phase)
            0: begin
                // power-on values
                settings.mode_select  = apm_pkg::RST_MODE_SELECT;
                settings.stick_center = apm_pkg::RST_STICK_CENTER;
                settings.stick_gain   = apm_pkg::RST_STICK_GAIN;
                settings.prop_gain    = apm_pkg::RST_PROP_GAIN;
                settings.rate_gain    = apm_pkg::RST_RATE_GAIN;
                settings.rudder_mix   = apm_pkg::RST_RUDDER_MIX;
                settings.out_mid      = apm_pkg::RST_OUT_MID;
                settings.out_min      = apm_pkg::RST_OUT_MIN;
            end
            1: begin
                settings.mode_select  = apm_pkg::SEL_BY_SWITCH;
                settings.stick_center = 12'($urandom_range(2000, 1000));
                settings.out_mid      = 12'($urandom_range(2000, 1000));
            end
            2: begin
                // every other field at its top value, PD law forced
                settings.mode_select  = {1'b0, apm_pkg::MODE_PD_LAST};
                settings.stick_center = '1;
                settings.stick_gain   = '1;
                settings.prop_gain    = '1;
                settings.rate_gain    = '1;
                settings.rudder_mix   = '1;
                settings.out_mid      = '1;
                settings.out_min      = '1;
            end
            3: begin
                settings.mode_select  = apm_pkg::SEL_BY_SWITCH;
                settings.stick_center = '0;
                settings.stick_gain   = '0;
                settings.prop_gain    = '0;
                settings.rate_gain    = '0;
                settings.rudder_mix   = '0;
                settings.out_mid      = '0;
                settings.out_min      = '0;
            end
            default: begin
                // gains spread over many magnitudes
                settings.mode_select  = $urandom_range(1, 0) ? apm_pkg::SEL_BY_SWITCH
                                                              : 4'($urandom_range(15, 0));
                settings.stick_center = $urandom_range(1, 0) ? 12'(near(1500, 200))
                                                              : 12'($urandom_range(4095, 0));
                settings.stick_gain   = 16'($urandom_range(65535, 0) >> $urandom_range(12, 0));
                settings.prop_gain    = 16'($urandom_range(65535, 0) >> $urandom_range(12, 0));
                settings.rate_gain    = 16'($urandom_range(65535, 0) >> $urandom_range(12, 0));
                settings.rudder_mix   = 8'($urandom_range(255, 0));
                settings.out_mid      = 12'($urandom_range(4095, 0));
                settings.out_min      = 12'($urandom_range(4095, 0));
            end
        endcase
    endtask

    initial begin
        stick_sample_t calm;
        int            gap_pct;
        int            pd_hits, default_hits;
        sb = new();
        settings = sb.regs;
        calm = make_sample(1200, 1600, 1400, 1550, 2000, 500, -300, 1000, -2000);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, power-on registers (mode picked by the switch) ----
        apply_settings();
        // switch exactly at the stick center stays manual, one above engages PD
        send(make_sample(1000, 1500, 1500, 1500, 1500, 0, 0, 0, 0));
        send(make_sample(1000, 1500, 1500, 1500, 1501, 0, 0, 0, 0));
        // drives pushed into both clamps
        send(make_sample(4095, 1500, 1500, 1500, 4095, 18000, 9000, 200000, 200000));
        send(make_sample(0, 1500, 1500, 1500, 4095, -18000, -9000, -200000, -200000));
        send(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // full-width field extremes
        send(make_sample(4095, 4095, 4095, 4095, 4095, -32768, -16384, -262144, -262144));
        send(make_sample(0, 0, 0, 0, 4095, 32767, 16383, 262143, 262143));
        send(calm);

        // forced manual ignores a high switch
        settings.mode_select = {1'b0, apm_pkg::MODE_MANUAL};
        apply_settings();
        send(make_sample(1234, 1700, 1300, 1900, 4095, 800, -800, 5000, -5000));

        // every forced mode above PD: 2..5 run the PD law, 6 and 7 give defaults
        for (int m = apm_pkg::MODE_PD + 1; m <= apm_pkg::MODE_BAD_SEL; m++) begin
            settings.mode_select = 4'(m);
            apply_settings();
            send(calm);
        end
        // negative selects other than the switch code report the bad-select mode
        for (int m = SEL_MOST_NEG; m < apm_pkg::SEL_BY_SWITCH; m += 6) begin
            settings.mode_select = 4'(m);
            apply_settings();
            send(calm);
        end

        // output saturation at the top: center at 4095 plus a full drive
        settings.mode_select = {1'b0, apm_pkg::MODE_PD};
        settings.prop_gain   = '1;
        settings.rate_gain   = '1;
        settings.out_mid     = '1;
        apply_settings();
        send(make_sample(1500, 1500, 1500, 1500, 0, -18000, 0, 0, 0));
        send(make_sample(1500, 1500, 1500, 1500, 0, 0, 9000, 0, 0));
        // and at the bottom: center at 0 minus a full drive
        settings.out_mid = '0;
        apply_settings();
        send(make_sample(1500, 1500, 1500, 1500, 0, 18000, 0, 0, 0));
        send(make_sample(1500, 1500, 1500, 1500, 0, 0, -9000, 0, 0));
        // all gains zero: every drive collapses to out_mid
        settings.stick_gain = '0;
        settings.prop_gain  = '0;
        settings.rate_gain  = '0;
        settings.rudder_mix = '0;
        settings.out_mid    = 12'd1700;
        apply_settings();
        send(make_sample(3000, 4000, 100, 2000, 4095, 12000, -7000, 150000, -150000));

        // ---- random part: register sets and idle patterns rotate per phase ----
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_settings(phase);
            apply_settings();
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 62; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 62; end
                default: begin gap_pct = 30; stall_pct = 30; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send(random_sample());
                // occasionally let the whole pipeline empty mid-stream
                if (n == PHASE_ITEMS / 2 || $urandom_range(199, 0) == 0)
                    drain_results(0);
                else
                    sender_gap(gap_pct);
            end
        end

        drain_results(DRAIN_CYCLES);

        pd_hits = 0;
        for (int m = apm_pkg::MODE_PD; m <= apm_pkg::MODE_PD_LAST; m++)
            pd_hits += sb.mode_hits[m];
        default_hits = sb.checked - pd_hits - sb.mode_hits[apm_pkg::MODE_MANUAL];
        $display("Run covered %0d requests (%0d results checked) across %0d register loads.",
                 requests, sb.checked, loads);
        $display("Results by mode: %0d manual, %0d PD law, %0d default outputs.",
                 sb.mode_hits[apm_pkg::MODE_MANUAL], pd_hits, default_hits);
        if (sb.errors == 0) begin
            $display("attitude_pd_mixer_core regression: pass");
        end else begin
            $display("attitude_pd_mixer_core regression: fail");
        end
        $finish;
    end

endmodule

FILE: attitude_pd_mixer_core.f
hw/rtl/apm_pkg.sv
hw/rtl/apm_cfg_regs.sv
hw/rtl/attitude_pd_mixer_core.sv
verif/tb_attitude_pd_mixer_core.sv
